[design/spcp_pkg.sv]
// Package for the spherical camera point projector.
// Holds the item structs, the fixed-point constants, the sequencer states and
// the CORDIC arctangent table. It depends on nothing else.
package spcp_pkg;

  typedef struct packed {
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic signed [31:0] local_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } spcp_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [63:0]        dist_sq;
    logic               on_screen;
  } spcp_out_t;

  // Configuration register indexes
  localparam logic [2:0] REG_CAM_X     = 3'd0;
  localparam logic [2:0] REG_CAM_Y     = 3'd1;
  localparam logic [2:0] REG_CAM_Z     = 3'd2;
  localparam logic [2:0] REG_CAM_YAW   = 3'd3;
  localparam logic [2:0] REG_CAM_PITCH = 3'd4;
  localparam logic [2:0] REG_H_FOV     = 3'd5;
  localparam logic [2:0] REG_V_FOV     = 3'd6;

  localparam logic [14:0] H_FOV_RST = 15'd4289;
  localparam logic [14:0] V_FOV_RST = 15'd3217;

  // Datapath widths: vector coordinates and Q30 angle accumulator
  localparam int VW = 40;
  localparam int AW = 36;

  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic [23:0]          GAIN_Q24    = 24'd10188014;

  localparam int DIV_STEPS = 32;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RLOAD,
    S_RRED,
    S_RFOLD,
    S_RSTEP,
    S_RGX,
    S_RGY,
    S_RGW,
    S_SQ,
    S_SQA,
    S_VLOAD,
    S_VPRE,
    S_VSTEP,
    S_VDONE,
    S_PMUL,
    S_PLOAD,
    S_PDIV,
    S_PFIN
  } spcp_state_t;

  // atan(2^-i) in Q30 radians
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[design/spherical_camera_point_projector_unit.sv]
// Top level of the spherical camera point projector.
// Depends on spcp_pkg for item types, constants and the arctangent table.
//
// One vertex is taken when start is high and busy is low; busy then stays
// high until the result strobe. An item passes through the two rotations
// (each wrapping its angle into -pi..pi when needed), the squared distance,
// the two arctangents (skipped when the forward coordinate is zero) and the
// two screen divisions. The work is done by the single CORDIC add/shift unit
// and the bit-serial divider, each doing one step per cycle, plus one shared
// multiplier. out_valid is high for exactly one cycle with out_item; the
// receiver cannot stall it.
// Configuration writes take effect at once.
module spherical_camera_point_projector_unit
  import spcp_pkg::*;
#(
  parameter int SCREEN_W     = 640,
  parameter int SCREEN_H     = 480,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  spcp_in_t    in_item,
  output logic        out_valid,
  output spcp_out_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [4:0]  LAST_STEP = 5'(CORDIC_STEPS - 1);
  localparam logic [13:0] SW        = 14'(SCREEN_W);
  localparam logic [13:0] SH        = 14'(SCREEN_H);

  // Configuration registers
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [15:0] cam_yaw_r, cam_pitch_r;
  logic [14:0]        h_fov_r, v_fov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r     <= '0;
      cam_y_r     <= '0;
      cam_z_r     <= '0;
      cam_yaw_r   <= '0;
      cam_pitch_r <= '0;
      h_fov_r     <= H_FOV_RST;
      v_fov_r     <= V_FOV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_X:     cam_x_r     <= cfg_wdata;
        REG_CAM_Y:     cam_y_r     <= cfg_wdata;
        REG_CAM_Z:     cam_z_r     <= cfg_wdata;
        REG_CAM_YAW:   cam_yaw_r   <= cfg_wdata[15:0];
        REG_CAM_PITCH: cam_pitch_r <= cfg_wdata[15:0];
        REG_H_FOV:     h_fov_r     <= cfg_wdata[14:0];
        REG_V_FOV:     v_fov_r     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  spcp_state_t          state_r, state_nxt;
  logic                 pass_r, pass_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [1:0]           sq_r, sq_nxt;
  logic [5:0]           dcnt_r, dcnt_nxt;
  logic signed [VW-1:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic signed [VW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [AW-1:0] ca_r, ca_nxt;
  logic [67:0]          prod_r, prod_nxt;
  logic                 sqsat_r, sqsat_nxt;
  logic [63:0]          dist_r, dist_nxt;
  logic signed [15:0]   ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [15:0]   sx_r, sx_nxt;
  logic                 nsign_r, nsign_nxt;
  logic [16:0]          rem_r, rem_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic                 out_valid_r, out_valid_nxt;
  spcp_out_t            out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r  <= pass_nxt;
    cnt_r   <= cnt_nxt;
    sq_r    <= sq_nxt;
    dcnt_r  <= dcnt_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    dz_r    <= dz_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    ca_r    <= ca_nxt;
    prod_r  <= prod_nxt;
    sqsat_r <= sqsat_nxt;
    dist_r  <= dist_nxt;
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    sx_r    <= sx_nxt;
    nsign_r <= nsign_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Shared multiplier, operands chosen by state
  logic [35:0] mul_a;
  logic [31:0] mul_b;
  logic [67:0] mul_p;
  assign mul_p = 68'(mul_a) * 68'(mul_b);

  // Shared CORDIC step
  logic signed [VW-1:0] sh_x, sh_y;
  logic signed [AW-1:0] tab;
  assign sh_x = cx_r >>> cnt_r;
  assign sh_y = cy_r >>> cnt_r;
  assign tab  = AW'(atan_q30(cnt_r));

  // Helpers
  logic [VW-1:0]        mag_x, mag_y, sq_mag;
  logic signed [VW-1:0] sq_v, gain_v;
  logic [35:0]          gain_m;
  logic [64:0]          acc_sum;
  logic [14:0]          fov;
  logic [15:0]          den;
  logic signed [17:0]   pnum;
  logic [17:0]          pmag;
  logic [13:0]          psize;
  logic [16:0]          trial;
  logic signed [32:0]   qs;
  logic signed [15:0]   qsat;
  logic signed [15:0]   ang;

  assign mag_x  = cx_r[VW-1] ? VW'(-cx_r) : VW'(cx_r);
  assign mag_y  = cy_r[VW-1] ? VW'(-cy_r) : VW'(cy_r);
  assign gain_m = prod_r[59:24];
  assign acc_sum = {1'b0, dist_r} + {1'b0, prod_r[63:0]};
  assign trial  = {rem_r[15:0], quo_r[31]} - {1'b0, den};
  assign qs     = nsign_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign qsat   = (qs > 33'sd32767) ? 16'sh7FFF :
                  (qs < -33'sd32768) ? 16'sh8000 : qs[15:0];

  always_comb begin
    unique case (sq_r)
      2'd0:    sq_v = dx_r;
      2'd1:    sq_v = dy_r;
      default: sq_v = dz_r;
    endcase
    sq_mag = sq_v[VW-1] ? VW'(-sq_v) : VW'(sq_v);
    fov    = pass_r ? v_fov_r : h_fov_r;
    if (fov == '0) fov = 15'd1;
    den    = {fov, 1'b0};
    ang    = pass_r ? ay_r : ax_r;
    pnum   = 18'(ang) + 18'(ang) + $signed({3'b0, fov});
    pmag   = pnum[17] ? 18'(-pnum) : 18'(pnum);
    psize  = pass_r ? SH : SW;
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    dcnt_nxt      = dcnt_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    ca_nxt        = ca_r;
    prod_nxt      = prod_r;
    sqsat_nxt     = sqsat_r;
    dist_nxt      = dist_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    sx_nxt        = sx_r;
    nsign_nxt     = nsign_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    gain_v        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          dx_nxt    = VW'(in_item.local_x) + VW'(in_item.offset_x) - VW'(cam_x_r);
          dy_nxt    = VW'(in_item.local_y) + VW'(in_item.offset_y) - VW'(cam_y_r);
          dz_nxt    = VW'(in_item.local_z) + VW'(in_item.offset_z) - VW'(cam_z_r);
          pass_nxt  = 1'b0;
          state_nxt = S_RLOAD;
        end
      end
      // Rotation: yaw on (x, y), then pitch on (z, x)
      S_RLOAD: begin
        if (!pass_r) begin
          cx_nxt = dx_r;
          cy_nxt = dy_r;
          ca_nxt = -$signed({{2{cam_yaw_r[15]}}, cam_yaw_r, 18'b0});
        end else begin
          cx_nxt = dz_r;
          cy_nxt = dx_r;
          ca_nxt = $signed({{2{cam_pitch_r[15]}}, cam_pitch_r, 18'b0});
        end
        state_nxt = S_RRED;
      end
      S_RRED: begin
        if (ca_r > PI_Q30) ca_nxt = ca_r - TWO_PI_Q30;
        else if (ca_r < -PI_Q30) ca_nxt = ca_r + TWO_PI_Q30;
        else state_nxt = S_RFOLD;
      end
      S_RFOLD: begin
        if (ca_r > HALF_PI_Q30) begin
          cx_nxt = -cx_r;
          cy_nxt = -cy_r;
          ca_nxt = ca_r - PI_Q30;
        end else if (ca_r < -HALF_PI_Q30) begin
          cx_nxt = -cx_r;
          cy_nxt = -cy_r;
          ca_nxt = ca_r + PI_Q30;
        end
        cnt_nxt   = '0;
        state_nxt = S_RSTEP;
      end
      S_RSTEP: begin
        if (!ca_r[AW-1]) begin
          cx_nxt = cx_r - sh_y;
          cy_nxt = cy_r + sh_x;
          ca_nxt = ca_r - tab;
        end else begin
          cx_nxt = cx_r + sh_y;
          cy_nxt = cy_r - sh_x;
          ca_nxt = ca_r + tab;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) state_nxt = S_RGX;
      end
      // Gain correction, magnitude truncated toward zero
      S_RGX: begin
        mul_a     = mag_x[35:0];
        mul_b     = 32'(GAIN_Q24);
        prod_nxt  = mul_p;
        state_nxt = S_RGY;
      end
      S_RGY: begin
        gain_v    = cx_r[VW-1] ? -VW'(gain_m) : VW'(gain_m);
        cx_nxt    = gain_v;
        mul_a     = mag_y[35:0];
        mul_b     = 32'(GAIN_Q24);
        prod_nxt  = mul_p;
        state_nxt = S_RGW;
      end
      S_RGW: begin
        gain_v = cy_r[VW-1] ? -VW'(gain_m) : VW'(gain_m);
        if (!pass_r) begin
          dx_nxt    = cx_r;
          dy_nxt    = gain_v;
          pass_nxt  = 1'b1;
          state_nxt = S_RLOAD;
        end else begin
          dz_nxt    = cx_r;
          dx_nxt    = gain_v;
          sq_nxt    = 2'd0;
          dist_nxt  = '0;
          state_nxt = S_SQ;
        end
      end
      // Squared distance, saturating
      S_SQ: begin
        mul_a     = {4'b0, sq_mag[31:0]};
        mul_b     = sq_mag[31:0];
        prod_nxt  = mul_p;
        sqsat_nxt = (sq_mag[VW-1:32] != '0);
        state_nxt = S_SQA;
      end
      S_SQA: begin
        dist_nxt = (sqsat_r || acc_sum[64]) ? '1 : acc_sum[63:0];
        pass_nxt = 1'b0;
        if (sq_r == 2'd2) begin
          if (dx_r == '0) begin
            ax_nxt    = '0;
            ay_nxt    = '0;
            state_nxt = S_PMUL;
          end else begin
            state_nxt = S_VLOAD;
          end
        end else begin
          sq_nxt    = sq_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      // Arctangent by vectoring: (dy, dx) then (dz, dx)
      S_VLOAD: begin
        cx_nxt    = dx_r;
        cy_nxt    = pass_r ? dz_r : dy_r;
        ca_nxt    = '0;
        state_nxt = S_VPRE;
      end
      S_VPRE: begin
        if (cx_r[VW-1]) begin
          if (!cy_r[VW-1]) begin
            cx_nxt = cy_r;
            cy_nxt = -cx_r;
            ca_nxt = HALF_PI_Q30;
          end else begin
            cx_nxt = -cy_r;
            cy_nxt = cx_r;
            ca_nxt = -HALF_PI_Q30;
          end
        end
        cnt_nxt   = '0;
        state_nxt = S_VSTEP;
      end
      S_VSTEP: begin
        if (!cy_r[VW-1]) begin
          cx_nxt = cx_r + sh_y;
          cy_nxt = cy_r - sh_x;
          ca_nxt = ca_r + tab;
        end else begin
          cx_nxt = cx_r - sh_y;
          cy_nxt = cy_r + sh_x;
          ca_nxt = ca_r - tab;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) state_nxt = S_VDONE;
      end
      S_VDONE: begin
        if (!pass_r) begin
          ax_nxt    = 16'(ca_r >>> 18);
          pass_nxt  = 1'b1;
          state_nxt = S_VLOAD;
        end else begin
          ay_nxt    = 16'(ca_r >>> 18);
          pass_nxt  = 1'b0;
          state_nxt = S_PMUL;
        end
      end
      // Projection: (2*ang + fov) * size / (2*fov), toward zero
      S_PMUL: begin
        mul_a     = 36'(pmag);
        mul_b     = 32'(psize);
        prod_nxt  = mul_p;
        nsign_nxt = pnum[17];
        state_nxt = S_PLOAD;
      end
      S_PLOAD: begin
        rem_nxt   = '0;
        quo_nxt   = prod_r[31:0];
        dcnt_nxt  = '0;
        state_nxt = S_PDIV;
      end
      S_PDIV: begin
        if (!trial[16]) begin
          rem_nxt = trial;
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[15:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'(DIV_STEPS - 1)) state_nxt = S_PFIN;
      end
      S_PFIN: begin
        if (!pass_r) begin
          sx_nxt    = qsat;
          pass_nxt  = 1'b1;
          state_nxt = S_PMUL;
        end else begin
          out_nxt.screen_x  = sx_r;
          out_nxt.screen_y  = qsat;
          out_nxt.dist_sq   = dist_r;
          out_nxt.on_screen = !sx_r[15] && (sx_r < $signed({2'b0, SW})) &&
                              !qsat[15] && (qsat < $signed({2'b0, SH}));
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[tb/spcp_checker.sv]
// Checker for the spherical camera point projector: tracks the configuration
// writes, predicts each accepted vertex and compares every result strobe.
// Depends on spcp_pkg for the item structs and the register indexes.
module spcp_checker
  import spcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  spcp_in_t    in_item,
  input  logic        out_valid,
  input  spcp_out_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SCR_W    = 640;
  localparam longint SCR_H    = 480;
  localparam int     N_STEPS  = 16;
  localparam longint PI30     = 64'sd3373259426;
  localparam longint HPI30    = 64'sd1686629713;
  localparam longint TWOPI30  = 64'sd6746518852;
  localparam longint K_Q24    = 64'sd10188014;

  localparam longint ATAN_Q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  // camera registers as the block holds them
  longint cx, cy, cz, yaw, pitch;
  logic [14:0] hfov, vfov;

  spcp_out_t proj_q[$];

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // magnitude scaling by the CORDIC gain, truncated toward zero
  function automatic longint cordic_gain(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m * K_Q24) >>> 24;
    return (v < 0) ? -m : m;
  endfunction

  function automatic void rotate_vec(inout longint x, inout longint y,
                                     input longint a);
    longint ddx, ddy;
    while (a > PI30) a -= TWOPI30;
    while (a < -PI30) a += TWOPI30;
    if (a > HPI30) begin
      x = -x; y = -y; a -= PI30;
    end else if (a < -HPI30) begin
      x = -x; y = -y; a += PI30;
    end
    for (int i = 0; i < N_STEPS && i < 24; i++) begin
      ddx = y >>> i;
      ddy = x >>> i;
      if (a >= 0) begin
        x -= ddx; y += ddy; a -= ATAN_Q30[i];
      end else begin
        x += ddx; y -= ddy; a += ATAN_Q30[i];
      end
    end
    x = cordic_gain(x);
    y = cordic_gain(y);
  endfunction

  // vectoring-mode arctangent, Q30 floored to Q3.12
  function automatic longint view_angle(longint y, longint x);
    longint z, t, ddx, ddy;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HPI30;
      end else begin
        x = -y; y = t; z = -HPI30;
      end
    end
    for (int i = 0; i < N_STEPS && i < 24; i++) begin
      ddx = y >>> i;
      ddy = x >>> i;
      if (y >= 0) begin
        x += ddx; y -= ddy; z += ATAN_Q30[i];
      end else begin
        x -= ddx; y += ddy; z -= ATAN_Q30[i];
      end
    end
    return z >>> 18;
  endfunction

  function automatic longint to_pixel(longint ang, logic [14:0] fov, longint size);
    longint f, q;
    f = (fov != 0) ? longint'(fov) : 1;
    q = ((2 * ang + f) * size) / (2 * f);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic logic [63:0] square_sat(longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    if (m >= 64'h1_0000_0000) return '1;
    return m * m;
  endfunction

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  function automatic spcp_out_t project_vertex(spcp_in_t v);
    longint px, py, pz, ax, ay, sx, sy;
    spcp_out_t r;
    px = sx32(v.local_x) + sx32(v.offset_x) - cx;
    py = sx32(v.local_y) + sx32(v.offset_y) - cy;
    pz = sx32(v.local_z) + sx32(v.offset_z) - cz;
    ax = 0;
    ay = 0;
    rotate_vec(px, py, -(yaw * 262144));
    rotate_vec(pz, px, pitch * 262144);
    r.dist_sq = sum_sat(sum_sat(square_sat(px), square_sat(py)), square_sat(pz));
    // zero forward coordinate leaves both view angles at zero
    if (px != 0) begin
      ax = view_angle(py, px);
      ay = view_angle(pz, px);
    end
    sx = to_pixel(ax, hfov, SCR_W);
    sy = to_pixel(ay, vfov, SCR_H);
    r.screen_x  = sx[15:0];
    r.screen_y  = sy[15:0];
    r.on_screen = (sx >= 0 && sx < SCR_W && sy >= 0 && sy < SCR_H);
    return r;
  endfunction

  always @(posedge clk) begin
    spcp_out_t exp_r;
    int nerr;
    nerr = 0;
    if (!rst_n) begin
      cx = 0; cy = 0; cz = 0; yaw = 0; pitch = 0;
      hfov = H_FOV_RST;
      vfov = V_FOV_RST;
      proj_q.delete();
      errors <= 0;
    end else begin
      // accepted vertex
      if (start && !busy) proj_q = {proj_q, project_vertex(in_item)};
      // result strobe
      if (out_valid) begin
        if (proj_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          nerr++;
        end else begin
          exp_r = proj_q.pop_front();
          if (exp_r.screen_x !== out_item.screen_x) begin
            $display("%0t: screen_x expected %0d got %0d", $time,
                     exp_r.screen_x, out_item.screen_x);
            nerr++;
          end
          if (exp_r.screen_y !== out_item.screen_y) begin
            $display("%0t: screen_y expected %0d got %0d", $time,
                     exp_r.screen_y, out_item.screen_y);
            nerr++;
          end
          if (exp_r.dist_sq !== out_item.dist_sq) begin
            $display("%0t: dist_sq expected %h got %h", $time,
                     exp_r.dist_sq, out_item.dist_sq);
            nerr++;
          end
          if (exp_r.on_screen !== out_item.on_screen) begin
            $display("%0t: on_screen expected %b got %b", $time,
                     exp_r.on_screen, out_item.on_screen);
            nerr++;
          end
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_CAM_X:     cx = sx32(cfg_wdata);
          REG_CAM_Y:     cy = sx32(cfg_wdata);
          REG_CAM_Z:     cz = sx32(cfg_wdata);
          REG_CAM_YAW:   yaw = longint'(signed'(cfg_wdata[15:0]));
          REG_CAM_PITCH: pitch = longint'(signed'(cfg_wdata[15:0]));
          REG_H_FOV:     hfov = cfg_wdata[14:0];
          REG_V_FOV:     vfov = cfg_wdata[14:0];
          default: ;
        endcase
      end
      errors <= errors + nerr;
    end
    pending <= proj_q.size();
  end

endmodule

[tb/tb_spherical_camera_point_projector_unit.sv]
// Testbench top for the spherical camera point projector: drives vertices and
// camera settings, idles the sender in phases and reports the verdict.
// Depends on spcp_pkg, the block and spcp_checker.
module tb_spherical_camera_point_projector_unit;
  import spcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // index that maps to no register
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  spcp_in_t    in_item = '0;
  logic        out_valid;
  spcp_out_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  int          errors;
  int          pending;
  int          gap_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spherical_camera_point_projector_unit u_top (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  spcp_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  // wait until every projection is back and the block is idle
  task automatic drain();
    do @(negedge clk); while (pending != 0 || busy || out_valid);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_camera(input logic [31:0] x, y, z, input logic [15:0] yw, pt,
                            input logic [14:0] hf, vf);
    start <= 1'b0;
    drain();
    write_reg(REG_CAM_X, x);
    write_reg(REG_CAM_Y, y);
    write_reg(REG_CAM_Z, z);
    write_reg(REG_CAM_YAW, {16'hA5A5, yw});
    write_reg(REG_CAM_PITCH, {16'h5A5A, pt});
    write_reg(REG_H_FOV, {17'h1ABCD, hf});
    write_reg(REG_V_FOV, {17'h0F0F0, vf});
  endtask

  // one vertex; start stays high across back-to-back items
  task automatic send_vertex(input spcp_in_t v);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= v;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    int pick;
    if (mode < 50) return 32'($urandom_range(0, 2097151)) - 32'd1048576;
    if (mode < 80) return $urandom;
    pick = $urandom_range(4);
    case (pick)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic spcp_in_t rand_vertex();
    spcp_in_t v;
    int mode;
    mode = $urandom_range(99);
    v.local_x  = rand_coord(mode);
    v.local_y  = rand_coord(mode);
    v.local_z  = rand_coord(mode);
    v.offset_x = rand_coord(mode);
    v.offset_y = rand_coord(mode);
    v.offset_z = rand_coord(mode);
    return v;
  endfunction

  function automatic spcp_in_t mk(logic [31:0] lx, ly, lz, ox, oy, oz);
    spcp_in_t v;
    v.local_x = lx; v.local_y = ly; v.local_z = lz;
    v.offset_x = ox; v.offset_y = oy; v.offset_z = oz;
    return v;
  endfunction

  initial begin
    #20_000_000;
    $display("[spherical_camera_point_projector_unit] ERROR");
    $finish;
  end

  initial begin
    gap_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default camera
    send_vertex(mk(0, 0, 0, 0, 0, 0));                         // zero forward
    send_vertex(mk(32'h0001_0000, 0, 0, 0, 0, 0));             // dead ahead
    send_vertex(mk(32'h0001_0000, 32'h0000_4000, 32'h0000_2000, 0, 0, 0));
    send_vertex(mk(32'h0001_0000, 32'hFFFF_C000, 32'hFFFF_E000, 0, 0, 0));
    send_vertex(mk(32'hFFFF_0000, 32'h0000_1000, 0, 0, 0, 0)); // behind
    send_vertex(mk(32'hFFFF_0000, 32'hFFFF_F000, 0, 0, 0, 0));
    send_vertex(mk(0, 32'h0005_0000, 32'h0003_0000, 0, 0, 0)); // zero forward
    send_vertex(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_vertex(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_vertex(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_vertex(mk(32'h0000_0001, 32'h7FFF_FFFF, 0, 0, 0, 0));
    send_vertex(mk(32'h0000_0001, 0, 32'h8000_0000, 0, 0, 0));
    // directed: narrowest view, screen saturation and unknown index
    set_camera(32'h0001_0000, 0, 0, 16'h7FFF, 16'h8000, 15'd1, 15'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_vertex(mk(32'h0010_0000, 32'h0008_0000, 32'h0004_0000, 0, 0, 0));
    send_vertex(mk(32'h0001_0000, 0, 0, 0, 0, 0));
    send_vertex(mk(32'hFFF0_0000, 32'hFFF8_0000, 32'h0004_0000, 0, 0, 0));
    // directed: widest view, extreme camera
    set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF,
               15'd25736, 15'd25736);
    send_vertex(mk(0, 0, 0, 0, 0, 0));
    send_vertex(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0C91, 16'hF36F,
               15'h7FFF, 15'h7FFF);
    send_vertex(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
    send_vertex(mk(0, 0, 0, 0, 0, 0));

    // random phases: each with its own camera, most with sender idling
    for (int ph = 0; ph < 12; ph++) begin
      gap_pct = 0;
      if (ph % 4 == 0) begin
        set_camera($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                   15'($urandom), 15'($urandom));
      end else begin
        set_camera(32'($urandom_range(0, 1048575)) - 32'd524288,
                   32'($urandom_range(0, 1048575)) - 32'd524288,
                   32'($urandom_range(0, 1048575)) - 32'd524288,
                   16'($urandom), 16'($urandom),
                   15'($urandom_range(1, 25736)), 15'($urandom_range(1, 25736)));
      end
      case (ph % 3)
        0: gap_pct = 0;
        1: gap_pct = 85;
        default: gap_pct = 6;
      endcase
      for (int n = 0; n < 75; n++) begin
        // hold off until every result is back and the block is idle
        if (ph == 5 && n % 10 == 0) begin
          start <= 1'b0;
          drain();
        end
        send_vertex(rand_vertex());
      end
    end
    start <= 1'b0;

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[spherical_camera_point_projector_unit] OK");
    end else begin
      $display("[spherical_camera_point_projector_unit] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/spcp_pkg.sv
design/spherical_camera_point_projector_unit.sv
tb/spcp_checker.sv
tb/tb_spherical_camera_point_projector_unit.sv
